@@ src/bfcr_pkg.sv @@
`timescale 1ns / 1ps

package bfcr_pkg;

    localparam int FRAMES_DEF     = 16;
    localparam int FILE_BITS_DEF  = 8;
    localparam int BLOCK_BITS_DEF = 16;

    localparam int ACTION_W = 2;

    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

    // top level -> sequencer
    typedef struct packed {
        logic start;
        logic out_free;
    } bfcr_ctl_t;

    // sequencer -> top level
    typedef struct packed {
        logic ready;
        logic push;
    } bfcr_stat_t;

    // tag compare unit result
    typedef struct packed {
        logic owner_eq;
        logic tag_eq;
    } bfcr_match_t;

endpackage

@@ src/bfcr_in_if.sv @@
`timescale 1ns / 1ps

interface bfcr_in_if #(
    parameter int FILE_BITS  = bfcr_pkg::FILE_BITS_DEF,
    parameter int BLOCK_BITS = bfcr_pkg::BLOCK_BITS_DEF
);
    import bfcr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [FILE_BITS-1:0]  file_id;
    logic [BLOCK_BITS-1:0] block_id;

    modport source (
        output valid, action, file_id, block_id,
        input  ready
    );

    modport sink (
        input  valid, action, file_id, block_id,
        output ready
    );

endinterface

@@ src/bfcr_out_if.sv @@
`timescale 1ns / 1ps

interface bfcr_out_if #(
    parameter int FRAMES     = bfcr_pkg::FRAMES_DEF,
    parameter int FILE_BITS  = bfcr_pkg::FILE_BITS_DEF,
    parameter int BLOCK_BITS = bfcr_pkg::BLOCK_BITS_DEF
);
    localparam int IW = $clog2(FRAMES);

    logic                  valid;
    logic                  ready;
    logic [IW-1:0]         frame;
    logic                  hit;
    logic                  load;
    logic                  write_back;
    logic [FILE_BITS-1:0]  wb_file;
    logic [BLOCK_BITS-1:0] wb_block;
    logic                  last;

    modport source (
        output valid, frame, hit, load, write_back, wb_file, wb_block, last,
        input  ready
    );

    modport sink (
        input  valid, frame, hit, load, write_back, wb_file, wb_block, last,
        output ready
    );

endinterface

@@ src/buffer_frame_clock_replacement_unit.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                                                   Handshake
// req      in   action, file_id, block_id                                 valid/ready
// rsp      out  frame, hit, load, write_back, wb_file, wb_block, last     valid/ready
//
// Tags live in a single-port-read RAM; the scan reads one frame per cycle unless a close stalls.
// A miss adds a clock sweep when every frame is owned, and a close waits while rsp stalls.
// Frame marks are flops cleared by reset, so no clearing pass is needed.
// req is ready only between transactions; a held result does not block it.
module buffer_frame_clock_replacement_unit #(
    parameter int FRAMES     = bfcr_pkg::FRAMES_DEF,
    parameter int FILE_BITS  = bfcr_pkg::FILE_BITS_DEF,
    parameter int BLOCK_BITS = bfcr_pkg::BLOCK_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bfcr_in_if.sink     req,
    bfcr_out_if.source  rsp
);
    import bfcr_pkg::*;

    localparam int IW = $clog2(FRAMES);

    bfcr_ctl_t             ctl;
    bfcr_stat_t            stat;

    logic [IW-1:0]         res_frame;
    logic                  res_hit;
    logic                  res_load;
    logic                  res_write_back;
    logic [FILE_BITS-1:0]  res_wb_file;
    logic [BLOCK_BITS-1:0] res_wb_block;
    logic                  res_last;

    logic                  out_vld_reg, out_vld_next;
    logic [IW-1:0]         out_frame_reg;
    logic                  out_hit_reg;
    logic                  out_load_reg;
    logic                  out_wb_reg;
    logic [FILE_BITS-1:0]  out_wbf_reg;
    logic [BLOCK_BITS-1:0] out_wbb_reg;
    logic                  out_last_reg;

    assign ctl.start    = req.valid && stat.ready;
    assign ctl.out_free = !out_vld_reg || rsp.ready;
    assign req.ready    = stat.ready;

    bfcr_seq #(
        .FRAMES     (FRAMES),
        .FILE_BITS  (FILE_BITS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .action         (req.action),
        .file_id        (req.file_id),
        .block_id       (req.block_id),
        .res_frame      (res_frame),
        .res_hit        (res_hit),
        .res_load       (res_load),
        .res_write_back (res_write_back),
        .res_wb_file    (res_wb_file),
        .res_wb_block   (res_wb_block),
        .res_last       (res_last)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (stat.push)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.push)
        begin
            out_frame_reg <= res_frame;
            out_hit_reg   <= res_hit;
            out_load_reg  <= res_load;
            out_wb_reg    <= res_write_back;
            out_wbf_reg   <= res_wb_file;
            out_wbb_reg   <= res_wb_block;
            out_last_reg  <= res_last;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.frame      = out_frame_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.load       = out_load_reg;
    assign rsp.write_back = out_wb_reg;
    assign rsp.wb_file    = out_wbf_reg;
    assign rsp.wb_block   = out_wbb_reg;
    assign rsp.last       = out_last_reg;

endmodule

@@ src/bfcr_ram.sv @@
`timescale 1ns / 1ps

module bfcr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/bfcr_tag_cmp.sv @@
`timescale 1ns / 1ps

module bfcr_tag_cmp #(
    parameter int FILE_BITS  = bfcr_pkg::FILE_BITS_DEF,
    parameter int BLOCK_BITS = bfcr_pkg::BLOCK_BITS_DEF
) (
    input  logic [FILE_BITS+BLOCK_BITS-1:0] tag,
    input  logic [FILE_BITS-1:0]            file_id,
    input  logic [BLOCK_BITS-1:0]           block_id,
    output bfcr_pkg::bfcr_match_t           result
);
    import bfcr_pkg::*;

    localparam int TW = FILE_BITS + BLOCK_BITS;

    logic owner_eq;

    assign owner_eq        = (tag[TW-1:BLOCK_BITS] == file_id);
    assign result.owner_eq = owner_eq;
    assign result.tag_eq   = owner_eq && (tag[BLOCK_BITS-1:0] == block_id);

endmodule

@@ src/bfcr_seq.sv @@
`timescale 1ns / 1ps

module bfcr_seq #(
    parameter int FRAMES     = bfcr_pkg::FRAMES_DEF,
    parameter int FILE_BITS  = bfcr_pkg::FILE_BITS_DEF,
    parameter int BLOCK_BITS = bfcr_pkg::BLOCK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfcr_pkg::bfcr_ctl_t           ctl,
    output bfcr_pkg::bfcr_stat_t          stat,
    input  logic [bfcr_pkg::ACTION_W-1:0] action,
    input  logic [FILE_BITS-1:0]          file_id,
    input  logic [BLOCK_BITS-1:0]         block_id,
    output logic [$clog2(FRAMES)-1:0]     res_frame,
    output logic                          res_hit,
    output logic                          res_load,
    output logic                          res_write_back,
    output logic [FILE_BITS-1:0]          res_wb_file,
    output logic [BLOCK_BITS-1:0]         res_wb_block,
    output logic                          res_last
);
    import bfcr_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int TW = FILE_BITS + BLOCK_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_VREAD = 3'd3;
    localparam logic [2:0] S_VCMP  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [ACTION_W-1:0]   act_reg, act_next;
    logic [FILE_BITS-1:0]  file_reg, file_next;
    logic [BLOCK_BITS-1:0] blk_reg, blk_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  free_vld_reg, free_vld_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic                  rel_vld_reg, rel_vld_next;
    logic [IW-1:0]         rel_idx_reg, rel_idx_next;
    logic [IW-1:0]         victim_reg, victim_next;
    logic [IW-1:0]         hand_reg, hand_next;
    logic [FRAMES-1:0]     alloc_reg, alloc_next;
    logic [FRAMES-1:0]     live_reg, live_next;
    logic [FRAMES-1:0]     dirty_reg, dirty_next;
    logic [FRAMES-1:0]     ref_reg, ref_next;

    logic                  pend_vld_reg, pend_vld_next;
    logic [IW-1:0]         pend_frame_reg, pend_frame_next;
    logic                  pend_hit_reg, pend_hit_next;
    logic                  pend_load_reg, pend_load_next;
    logic                  pend_wb_reg, pend_wb_next;
    logic [FILE_BITS-1:0]  pend_wbf_reg, pend_wbf_next;
    logic [BLOCK_BITS-1:0] pend_wbb_reg, pend_wbb_next;
    logic                  pend_last_reg, pend_last_next;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [TW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [TW-1:0]         ram_rdata;

    bfcr_match_t           cmp_res;
    logic                  is_close;
    logic                  close_match;
    logic                  stall;
    logic                  fv, rv;
    logic [IW-1:0]         fi, ri;
    logic                  victim_wb;
    logic                  push;

    bfcr_ram #(
        .WIDTH (TW),
        .DEPTH (FRAMES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfcr_tag_cmp #(
        .FILE_BITS  (FILE_BITS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_tag_cmp (
        .tag      (ram_rdata),
        .file_id  (file_reg),
        .block_id (blk_reg),
        .result   (cmp_res)
    );

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] h);
        return (h == IW'(FRAMES - 1)) ? '0 : h + IW'(1);
    endfunction

    assign is_close    = (act_reg == ACT_CLOSE);
    assign close_match = live_reg[cmp_idx_reg] && cmp_res.owner_eq;
    // a second close match needs the held result drained first
    assign stall       = cmp_vld_reg && is_close && close_match && pend_vld_reg
                         && !ctl.out_free;
    assign victim_wb   = live_reg[victim_reg] && dirty_reg[victim_reg];

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        file_next       = file_reg;
        blk_next        = blk_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        rel_vld_next    = rel_vld_reg;
        rel_idx_next    = rel_idx_reg;
        victim_next     = victim_reg;
        hand_next       = hand_reg;
        alloc_next      = alloc_reg;
        live_next       = live_reg;
        dirty_next      = dirty_reg;
        ref_next        = ref_reg;
        pend_vld_next   = pend_vld_reg;
        pend_frame_next = pend_frame_reg;
        pend_hit_next   = pend_hit_reg;
        pend_load_next  = pend_load_reg;
        pend_wb_next    = pend_wb_reg;
        pend_wbf_next   = pend_wbf_reg;
        pend_wbb_next   = pend_wbb_reg;
        pend_last_next  = pend_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = victim_reg;
        ram_wdata       = {file_reg, blk_reg};
        ram_re          = 1'b0;
        ram_raddr       = victim_reg;
        push            = 1'b0;
        fv              = free_vld_reg;
        fi              = free_idx_reg;
        rv              = rel_vld_reg;
        ri              = rel_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    act_next  = action;
                    file_next = file_id;
                    blk_next  = block_id;
                    if ((file_id != '0) && ((action == ACT_READ) || (action == ACT_WRITE)
                                            || (action == ACT_CLOSE)))
                    begin
                        state_next    = S_SCAN;
                        scan_next     = '0;
                        cmp_vld_next  = 1'b0;
                        free_vld_next = 1'b0;
                        rel_vld_next  = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    // issue stage: one tag read per cycle while not stalled
                    if (scan_reg < CW'(FRAMES))
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = scan_reg[IW-1:0];
                        cmp_vld_next = 1'b1;
                        cmp_idx_next = scan_reg[IW-1:0];
                        scan_next    = scan_reg + CW'(1);
                    end
                    else
                    begin
                        cmp_vld_next = 1'b0;
                    end

                    // compare stage
                    if (cmp_vld_reg)
                    begin
                        if (!fv && !alloc_reg[cmp_idx_reg])
                        begin
                            fv = 1'b1;
                            fi = cmp_idx_reg;
                        end
                        if (!rv && !live_reg[cmp_idx_reg])
                        begin
                            rv = 1'b1;
                            ri = cmp_idx_reg;
                        end
                        free_vld_next = fv;
                        free_idx_next = fi;
                        rel_vld_next  = rv;
                        rel_idx_next  = ri;

                        if (!is_close && live_reg[cmp_idx_reg] && cmp_res.tag_eq)
                        begin
                            ref_next[cmp_idx_reg] = 1'b1;
                            if (act_reg == ACT_WRITE)
                            begin
                                dirty_next[cmp_idx_reg] = 1'b1;
                            end
                            pend_vld_next   = 1'b1;
                            pend_frame_next = cmp_idx_reg;
                            pend_hit_next   = 1'b1;
                            pend_load_next  = 1'b0;
                            pend_wb_next    = 1'b0;
                            pend_wbf_next   = '0;
                            pend_wbb_next   = '0;
                            pend_last_next  = 1'b1;
                            cmp_vld_next    = 1'b0;
                            state_next      = S_FLUSH;
                        end
                        else
                        begin
                            if (is_close && close_match)
                            begin
                                push                      = pend_vld_reg;
                                live_next[cmp_idx_reg]  = 1'b0;
                                dirty_next[cmp_idx_reg] = 1'b0;
                                ref_next[cmp_idx_reg]   = 1'b0;
                                pend_vld_next   = 1'b1;
                                pend_frame_next = cmp_idx_reg;
                                pend_hit_next   = 1'b0;
                                pend_load_next  = 1'b0;
                                pend_wb_next    = dirty_reg[cmp_idx_reg];
                                pend_wbf_next   = dirty_reg[cmp_idx_reg] ? file_reg : '0;
                                pend_wbb_next   = dirty_reg[cmp_idx_reg]
                                                  ? ram_rdata[BLOCK_BITS-1:0] : '0;
                                pend_last_next  = 1'b0;
                            end

                            if (cmp_idx_reg == IW'(FRAMES - 1))
                            begin
                                cmp_vld_next = 1'b0;
                                if (is_close)
                                begin
                                    if (pend_vld_next)
                                    begin
                                        pend_last_next = 1'b1;
                                        state_next     = S_FLUSH;
                                    end
                                    else
                                    begin
                                        state_next = S_IDLE;
                                    end
                                end
                                else if (fv)
                                begin
                                    victim_next = fi;
                                    state_next  = S_VREAD;
                                end
                                else if (rv)
                                begin
                                    victim_next = ri;
                                    state_next  = S_VREAD;
                                end
                                else
                                begin
                                    state_next = S_SWEEP;
                                end
                            end
                        end
                    end
                end
            end

            S_SWEEP:
            begin
                hand_next = advance(hand_reg);
                if (ref_reg[hand_reg])
                begin
                    ref_next[hand_reg] = 1'b0;
                end
                else
                begin
                    victim_next = hand_reg;
                    state_next  = S_VREAD;
                end
            end

            S_VREAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = victim_reg;
                state_next = S_VCMP;
            end

            S_VCMP:
            begin
                pend_vld_next   = 1'b1;
                pend_frame_next = victim_reg;
                pend_hit_next   = 1'b0;
                pend_load_next  = 1'b1;
                pend_wb_next    = victim_wb;
                pend_wbf_next   = victim_wb ? ram_rdata[TW-1:BLOCK_BITS] : '0;
                pend_wbb_next   = victim_wb ? ram_rdata[BLOCK_BITS-1:0] : '0;
                pend_last_next  = 1'b1;
                ram_we          = 1'b1;
                alloc_next[victim_reg] = 1'b1;
                live_next[victim_reg]  = 1'b1;
                dirty_next[victim_reg] = (act_reg == ACT_WRITE);
                ref_next[victim_reg]   = 1'b1;
                state_next             = S_FLUSH;
            end

            S_FLUSH:
            begin
                if (ctl.out_free)
                begin
                    push          = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            rel_vld_reg  <= 1'b0;
            hand_reg     <= '0;
            alloc_reg    <= '0;
            live_reg     <= '0;
            dirty_reg    <= '0;
            ref_reg      <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            cmp_vld_reg  <= cmp_vld_next;
            free_vld_reg <= free_vld_next;
            rel_vld_reg  <= rel_vld_next;
            hand_reg     <= hand_next;
            alloc_reg    <= alloc_next;
            live_reg     <= live_next;
            dirty_reg    <= dirty_next;
            ref_reg      <= ref_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        file_reg       <= file_next;
        blk_reg        <= blk_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_idx_reg   <= free_idx_next;
        rel_idx_reg    <= rel_idx_next;
        victim_reg     <= victim_next;
        pend_frame_reg <= pend_frame_next;
        pend_hit_reg   <= pend_hit_next;
        pend_load_reg  <= pend_load_next;
        pend_wb_reg    <= pend_wb_next;
        pend_wbf_reg   <= pend_wbf_next;
        pend_wbb_reg   <= pend_wbb_next;
        pend_last_reg  <= pend_last_next;
    end

    assign stat.ready     = (state_reg == S_IDLE);
    assign stat.push      = push;
    assign res_frame      = pend_frame_reg;
    assign res_hit        = pend_hit_reg;
    assign res_load       = pend_load_reg;
    assign res_write_back = pend_wb_reg;
    assign res_wb_file    = pend_wbf_reg;
    assign res_wb_block   = pend_wbb_reg;
    assign res_last       = pend_last_reg;

endmodule

@@ tb/tb_buffer_frame_clock_replacement_unit.sv @@
`timescale 1ns / 1ps

module tb_buffer_frame_clock_replacement_unit;
    import bfcr_pkg::*;

    localparam int NF = FRAMES_DEF;
    localparam int FW = FILE_BITS_DEF;
    localparam int BW = BLOCK_BITS_DEF;
    localparam int IW = $clog2(NF);

    // action code the block must drop
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam int RESET_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 105;

    typedef struct packed {
        logic [IW-1:0] frame;
        logic          hit;
        logic          load;
        logic          write_back;
        logic [FW-1:0] wb_file;
        logic [BW-1:0] wb_block;
        logic          last;
    } frame_result_t;

    class frame_table_scoreboard;
        logic          in_use [NF];
        logic [FW-1:0] owner  [NF];
        logic [BW-1:0] blk    [NF];
        logic          dirty  [NF];
        logic          refd   [NF];
        int            hand;
        frame_result_t pending_q [$];
        int errors;
        int n_hits;
        int n_loads;
        int n_wb;
        int n_released;
        int n_ignored;

        function new();
            for (int i = 0; i < NF; i++)
            begin
                in_use[i] = 1'b0;
                owner[i]  = '0;
                blk[i]    = '0;
                dirty[i]  = 1'b0;
                refd[i]   = 1'b0;
            end
            hand       = 0;
            errors     = 0;
            n_hits     = 0;
            n_loads    = 0;
            n_wb       = 0;
            n_released = 0;
            n_ignored  = 0;
        endfunction

        function void add_expected(frame_result_t r);
            pending_q = {pending_q, r};
        endfunction

        // free frame first, then a released one, then the clock sweep
        function int pick_frame();
            int h;
            for (int i = 0; i < NF; i++)
                if (!in_use[i])
                    return i;
            for (int i = 0; i < NF; i++)
                if (owner[i] == '0)
                    return i;
            h = hand;
            while (refd[h])
            begin
                refd[h] = 1'b0;
                h = (h + 1) % NF;
            end
            refd[h] = 1'b1;
            hand = (h + 1) % NF;
            return h;
        endfunction

        function void note_request(logic [ACTION_W-1:0] action, logic [FW-1:0] file,
                                   logic [BW-1:0] block);
            frame_result_t r;
            int            first;
            int            v;
            if (file == '0 || action == ACT_NONE)
            begin
                n_ignored++;
                return;
            end
            if (action == ACT_CLOSE)
            begin
                first = pending_q.size();
                for (int i = 0; i < NF; i++)
                begin
                    if (in_use[i] && owner[i] == file)
                    begin
                        r = '0;
                        r.frame = IW'(i);
                        r.write_back = dirty[i];
                        if (dirty[i])
                        begin
                            r.wb_file  = owner[i];
                            r.wb_block = blk[i];
                            n_wb++;
                        end
                        add_expected(r);
                        n_released++;
                        owner[i] = '0;
                        dirty[i] = 1'b0;
                        refd[i]  = 1'b0;
                    end
                end
                if (pending_q.size() > first)
                    pending_q[pending_q.size()-1].last = 1'b1;
                return;
            end
            for (int i = 0; i < NF; i++)
            begin
                if (in_use[i] && owner[i] == file && blk[i] == block)
                begin
                    refd[i] = 1'b1;
                    if (action == ACT_WRITE)
                        dirty[i] = 1'b1;
                    r = '0;
                    r.frame = IW'(i);
                    r.hit   = 1'b1;
                    r.last  = 1'b1;
                    add_expected(r);
                    n_hits++;
                    return;
                end
            end
            v = pick_frame();
            r = '0;
            r.frame = IW'(v);
            r.load  = 1'b1;
            r.last  = 1'b1;
            if (in_use[v] && owner[v] != '0 && dirty[v])
            begin
                r.write_back = 1'b1;
                r.wb_file    = owner[v];
                r.wb_block   = blk[v];
                n_wb++;
            end
            add_expected(r);
            n_loads++;
            in_use[v] = 1'b1;
            owner[v]  = file;
            blk[v]    = block;
            dirty[v]  = (action == ACT_WRITE);
            refd[v]   = 1'b1;
        endfunction

        task report(string msg);
            $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(frame_result_t got);
            frame_result_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result, frame %0d", got.frame));
                return;
            end
            want = pending_q.pop_front();
            check_field("frame",      32'(got.frame),      32'(want.frame));
            check_field("hit",        32'(got.hit),        32'(want.hit));
            check_field("load",       32'(got.load),       32'(want.load));
            check_field("write_back", 32'(got.write_back), 32'(want.write_back));
            check_field("wb_file",    32'(got.wb_file),    32'(want.wb_file));
            check_field("wb_block",   32'(got.wb_block),   32'(want.wb_block));
            check_field("last",       32'(got.last),       32'(want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bfcr_in_if  req ();
    bfcr_out_if rsp ();

    buffer_frame_clock_replacement_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    frame_table_scoreboard sb;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int quiet_cycles;

    always #2 clk = ~clk;

    task automatic send_item(logic [ACTION_W-1:0] action, logic [FW-1:0] file,
                             logic [BW-1:0] block);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.action   <= action;
        req.file_id  <= file;
        req.block_id <= block;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(action, file, block);
    endtask

    // few files and blocks so that hits, sweeps and closes are frequent
    task automatic send_random_phase(int count);
        logic [ACTION_W-1:0] a;
        logic [FW-1:0]       f;
        logic [BW-1:0]       b;
        int                  done;
        int                  roll;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                a = ACT_NONE;
            else if (roll < 11)
                a = ACT_CLOSE;
            else if (roll < 50)
                a = ACT_WRITE;
            else
                a = ACT_READ;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                f = '0;
            else if (roll < 10)
                f = FW'($urandom_range(1, 255));
            else
                f = FW'($urandom_range(1, 5));
            if ($urandom_range(0, 99) < 15)
                b = BW'($urandom);
            else
                b = BW'($urandom_range(0, 7));
            send_item(a, f, b);
            if (f != '0 && a != ACT_NONE)
                done++;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        frame_result_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.frame, rsp.hit, rsp.load, rsp.write_back,
                   rsp.wb_file, rsp.wb_block, rsp.last};
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: %0d cycles without a transaction", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        sb = new();
        send_idle_pct = 31;
        recv_idle_pct = 77;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        rst_n        <= 1'b0;
        req.valid    <= 1'b0;
        req.action   <= ACT_READ;
        req.file_id  <= '0;
        req.block_id <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hits, extremes, dropped requests, full table, sweep, closes
        send_item(ACT_WRITE, 8'd1,   16'd0);
        send_item(ACT_READ,  8'd1,   16'd0);
        send_item(ACT_READ,  8'd255, 16'hFFFF);
        send_item(ACT_WRITE, 8'd255, 16'hFFFF);
        send_item(ACT_READ,  8'd0,   16'd5);
        send_item(ACT_NONE,  8'd1,   16'd0);
        send_item(ACT_CLOSE, 8'd9,   16'd0);
        for (int i = 1; i <= NF - 2; i++)
            send_item((i % 2 == 1) ? ACT_WRITE : ACT_READ, 8'd2, BW'(i));
        // table full and all referenced: sweep wraps and evicts dirty frame 0
        send_item(ACT_READ,  8'd3,   16'd100);
        send_item(ACT_CLOSE, 8'd2,   16'hABCD);
        send_item(ACT_WRITE, 8'd1,   16'hFFFF);
        send_item(ACT_CLOSE, 8'd255, 16'd0);

        send_random_phase(PHASE_ITEMS);
        send_idle_pct = 77;
        recv_idle_pct = 31;
        send_random_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        send_random_phase(PHASE_ITEMS);

        req.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d hits, %0d loads, %0d write-backs, %0d frames freed by close",
                 sb.n_hits, sb.n_loads, sb.n_wb, sb.n_released);
        $display("plus %0d dropped requests, three idle mixes and a %0d-cycle result stall",
                 sb.n_ignored, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
